FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types, verdict codes and byte classification for the bracket checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] verdict_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  localparam verdict_t VERDICT_OK        = 3'd0;
  localparam verdict_t VERDICT_BAD_CLOSE = 3'd1;
  localparam verdict_t VERDICT_INVALID   = 3'd2;
  localparam verdict_t VERDICT_UNCLOSED  = 3'd3;
  localparam verdict_t VERDICT_OVERFLOW  = 3'd4;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    case (ch)
      CHAR_OPEN_ROUND: begin
        c.is_open = 1'b1;
        c.kind    = KIND_ROUND;
      end
      CHAR_CLOSE_ROUND: begin
        c.is_close = 1'b1;
        c.kind     = KIND_ROUND;
      end
      CHAR_OPEN_SQUARE: begin
        c.is_open = 1'b1;
        c.kind    = KIND_SQUARE;
      end
      CHAR_CLOSE_SQUARE: begin
        c.is_close = 1'b1;
        c.kind     = KIND_SQUARE;
      end
      CHAR_OPEN_CURLY: begin
        c.is_open = 1'b1;
        c.kind    = KIND_CURLY;
      end
      CHAR_CLOSE_CURLY: begin
        c.is_close = 1'b1;
        c.kind     = KIND_CURLY;
      end
      default: begin
        c.is_open  = 1'b0;
        c.is_close = 1'b0;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// one stack slot of the shifting bracket stack
// ----------------------------------------------------------------------------
module bbc_cell
  import bbc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  kind_t     up_kind,
  input  kind_t     dn_kind,
  output kind_t     kind
);

  kind_t kind_r;
  kind_t kind_nxt;

  always_comb begin
    kind_nxt = kind_r;
    if (ctl.push) begin
      kind_nxt = up_kind;
    end else if (ctl.pop) begin
      kind_nxt = dn_kind;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind = kind_r;

endmodule

FILE: rtl/bracket_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// checks a byte stream for balanced (), [] and {} brackets
// ----------------------------------------------------------------------------
// Takes one text byte per cycle, back to back, and answers each end-of-text
// transaction with one verdict in the next cycle through an output register.
// The bracket stack is a row of STACK_DEPTH shifting cells with the top in
// the first cell, so a push or pop is a single shift of the cells; the
// per-byte work is one top-of-stack compare and a depth update.
// The first error of a text is held and later bytes are ignored until the
// end transaction, which clears the depth and error for the next text.
// Input is held off only while a verdict waits and the output is stalled.
module bracket_balance_checker_unit
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_verdict
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  verdict_t         err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  verdict_t         out_verdict_r, out_verdict_nxt;

  logic        accept;
  char_class_t cls;
  cell_ctl_t   ctl;
  kind_t       kind_w [STACK_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cls      = classify(in_text_byte);

  always_comb begin
    count_nxt       = count_r;
    err_nxt         = err_r;
    ctl             = '{push: 1'b0, pop: 1'b0};
    out_valid_nxt   = out_valid_r && !out_ready;
    out_verdict_nxt = out_verdict_r;
    if (accept) begin
      if (in_end_of_text) begin
        out_valid_nxt = 1'b1;
        if (err_r != VERDICT_OK) begin
          out_verdict_nxt = err_r;
        end else if (count_r != '0) begin
          out_verdict_nxt = VERDICT_UNCLOSED;
        end else begin
          out_verdict_nxt = VERDICT_OK;
        end
        count_nxt = '0;
        err_nxt   = VERDICT_OK;
      end else if (err_r == VERDICT_OK) begin
        if (cls.is_open) begin
          if (count_r == CNT_FULL) begin
            err_nxt = VERDICT_OVERFLOW;
          end else begin
            ctl.push  = 1'b1;
            count_nxt = count_r + CNT_ONE;
          end
        end else if (cls.is_close) begin
          if (count_r == '0 || kind_w[0] != cls.kind) begin
            err_nxt = VERDICT_BAD_CLOSE;
          end else begin
            ctl.pop   = 1'b1;
            count_nxt = count_r - CNT_ONE;
          end
        end else begin
          err_nxt = VERDICT_INVALID;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= VERDICT_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t up_kind;
    kind_t dn_kind;
    if (i == 0) begin : g_top
      assign up_kind = cls.kind;
    end else begin : g_mid
      assign up_kind = kind_w[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign dn_kind = kind_w[i];
    end else begin : g_rest
      assign dn_kind = kind_w[i+1];
    end
    bbc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .up_kind (up_kind),
      .dn_kind (dn_kind),
      .kind    (kind_w[i])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule
